>>> design/dqd_pkg.sv
// Shared types, constants and helpers for the deque with delete-by-value.
// No dependencies; imported by deque_with_delete_by_value_top.
package dqd_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ITEM_W = 32;
   localparam int LEN_W  = 7;
   localparam int OP_W   = 2;
   localparam int STS_W  = 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_PREPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd3;

   // status codes
   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
   localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ITEM_W-1:0] item_type;

   // Physical slot of the entry at a given offset from the head.
   // head < DEPTH and offset <= DEPTH, so one conditional subtract wraps it.
   function automatic idx_type slot_of(input idx_type head, input cnt_type offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(offset);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> design/deque_with_delete_by_value_top.sv
// Top level of the bounded deque of item handles with delete-by-value.
// Depends on dqd_pkg (depth, widths, opcodes, status codes, slot_of).
// ---------------------------------------------------------------------------
// Bounded double-ended queue of 32-bit handles, DEPTH (64) entries held in a
// circular single-port-write, single-port-read RAM. Each request transaction
// (req_tuser = opcode, req_tdata = item) yields exactly one response
// transaction carrying a status, the dequeued item (0 unless a dequeue
// succeeds) and the length after the request. Opcodes: prepend, append,
// dequeue head, delete first entry equal to the item (later entries slide one
// place toward the head, order kept). Full inserts report FULL and change
// nothing; dequeue or delete when empty report EMPTY; a delete with no match
// reports NOT_FOUND. One request is worked at a time by a small sequencer
// around the RAM and one comparator/slot adder; req_tready is high only while
// the sequencer is idle. Prepend, append and dequeue finish in the decode
// state; delete then scans the entries from the head, one RAM read per
// scanned entry, and moves each later entry with a read/write pair. A new
// request may be accepted while the previous response still waits for
// rsp_tready; the result then parks until the output register is free.
// ---------------------------------------------------------------------------
module deque_with_delete_by_value_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] item_in
   input  logic [dqd_pkg::OP_W-1:0]   req_tuser,   // [1:0] opcode
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [39:0]                rsp_tdata,   // [31:0] item_out, [38:32] length_now
   output logic [dqd_pkg::STS_W-1:0]  rsp_tuser    // [1:0] status
);
   import dqd_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
   localparam logic [2:0] S_EXEC  = 3'd1;  // decode and do single-step ops
   localparam logic [2:0] S_SCAN  = 3'd2;  // delete: compare one entry a cycle
   localparam logic [2:0] S_SH_RD = 3'd3;  // delete: read next entry to move
   localparam logic [2:0] S_SH_WR = 3'd4;  // delete: write it one place up
   localparam logic [2:0] S_RESP  = 3'd5;  // result parked, output busy

   // control state
   logic [2:0]        state_ff, state_in;
   idx_type           head_ff, head_in;
   cnt_type           count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working payload
   logic [OP_W-1:0]   op_ff, op_in;
   item_type          key_ff, key_in;
   cnt_type           pos_ff, pos_in;

   // parked result
   logic [STS_W-1:0]  res_status_ff, res_status_in;
   item_type          res_item_ff, res_item_in;
   logic [LEN_W-1:0]  res_len_ff, res_len_in;

   // output register
   logic [STS_W-1:0]  rsp_status_ff, rsp_status_in;
   item_type          rsp_item_ff, rsp_item_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   // entry RAM
   item_type          entry_store_ff [DEPTH];
   item_type          rd_data_ff;
   idx_type           rd_addr;
   idx_type           wr_addr;
   item_type          wr_data;
   logic              wr_en;

   // finish of a request
   logic              fin;
   logic [STS_W-1:0]  fin_status;
   item_type          fin_item;
   logic              slot_free;
   cnt_type           pos_nxt;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign pos_nxt   = pos_ff + CNT_W'(1);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_item_in   = res_item_ff;
      res_len_in    = res_len_ff;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rd_addr       = head_ff;
      wr_addr       = head_ff;
      wr_data       = key_ff;
      wr_en         = 1'b0;
      fin           = 1'b0;
      fin_status    = STS_OK;
      fin_item      = '0;

      case (state_ff)
         S_IDLE: begin
            // head read issued here so a dequeue has its data in S_EXEC
            if (req_tvalid) begin
               op_in    = req_tuser;
               key_in   = req_tdata;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_PREPEND: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     fin        = 1'b1;
                     fin_status = STS_FULL;
                  end else begin
                     head_in  = (head_ff == '0) ? IDX_W'(DEPTH - 1)
                                                : head_ff - IDX_W'(1);
                     wr_en    = 1'b1;
                     wr_addr  = head_in;
                     count_in = count_ff + CNT_W'(1);
                     fin      = 1'b1;
                  end
               end
               OP_APPEND: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     fin        = 1'b1;
                     fin_status = STS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot_of(head_ff, count_ff);
                     count_in = count_ff + CNT_W'(1);
                     fin      = 1'b1;
                  end
               end
               OP_DEQUEUE: begin
                  if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = STS_EMPTY;
                  end else begin
                     fin_item = rd_data_ff;
                     head_in  = slot_of(head_ff, CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                     fin      = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = STS_EMPTY;
                  end else begin
                     pos_in   = '0;
                     rd_addr  = head_ff;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // rd_data_ff holds the entry at pos; prefetch the one after it
            rd_addr = slot_of(head_ff, pos_nxt);
            if (rd_data_ff == key_ff) begin
               state_in = S_SH_RD;
            end else if (pos_nxt >= count_ff) begin
               fin        = 1'b1;
               fin_status = STS_NOT_FOUND;
            end else begin
               pos_in = pos_nxt;
            end
         end
         S_SH_RD: begin
            if (pos_nxt >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               fin      = 1'b1;
            end else begin
               rd_addr  = slot_of(head_ff, pos_nxt);
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(head_ff, pos_ff);
            wr_data  = rd_data_ff;
            pos_in   = pos_nxt;
            state_in = S_SH_RD;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_status_in = res_status_ff;
               rsp_item_in   = res_item_ff;
               rsp_len_in    = res_len_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // deliver straight to the output register, or park if it is occupied
      if (fin) begin
         if (slot_free) begin
            rsp_status_in = fin_status;
            rsp_item_in   = fin_item;
            rsp_len_in    = LEN_W'(count_in);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end else begin
            res_status_in = fin_status;
            res_item_in   = fin_item;
            res_len_in    = LEN_W'(count_in);
            state_in      = S_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_item_ff   <= res_item_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // entry RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_item_ff};

   // ---------------------------------------------------------------- checks
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_accept_to_exec : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted transaction not decoded");

   a_full_no_change : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXEC) && (count_ff == CNT_W'(DEPTH)) &&
       ((op_ff == OP_PREPEND) || (op_ff == OP_APPEND)))
      |=> ((count_ff == $past(count_ff)) && (head_ff == $past(head_ff))))
      else $error("insert into full deque changed state");

   a_write_busy_only : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_EXEC) || (state_ff == S_SH_WR)))
      else $error("RAM write outside a working state");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for deque_with_delete_by_value_top: directed table, then random traffic.
// Depends on dqd_pkg and the RTL top; needs nothing else.
module tb;
   import dqd_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int ITEMS_PER_PASS = 500;   // three passes, about 1500 transactions
   localparam int HOLD_CYCLES    = 500;   // long receiver hold-off to back up the block
   localparam int IDLE_LIMIT     = 4000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES   = 20;
   localparam int MAX_REPORTS    = 10;

   // one response transaction: status, dequeued item, length after the request
   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [ITEM_W-1:0] item;
      logic [LEN_W-1:0]  len;
   } deque_rsp_type;

   // directed row: request, and a typed expectation where 'fixed' is set
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ITEM_W-1:0] item;
      logic              fixed;
      deque_rsp_type     want;
   } deque_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;
   logic [OP_W-1:0]   req_tuser  = OP_PREPEND;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;
   logic [STS_W-1:0]  rsp_tuser;

   // predictor state: held entries in logical order, head first
   logic [ITEM_W-1:0] held_items[$];
   // responses owed by the block, oldest first
   deque_rsp_type     owed_rsp[$];

   int  fail_count    = 0;
   int  idle_cycles   = 0;
   int  send_idle_pct = 13;
   int  recv_idle_pct = 61;
   int  sent_in_pass  = 0;
   bit  hold_pending  = 1'b0;

   deque_row_type directed_rows [19];

   deque_with_delete_by_value_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: applies one accepted request to held_items and returns the
   // response the block owes for it.
   // ---------------------------------------------------------------------
   function automatic deque_rsp_type apply_request(input logic [OP_W-1:0] op,
                                                   input logic [ITEM_W-1:0] key);
      deque_rsp_type r;
      int            pos;
      r   = '{STS_OK, '0, '0};
      pos = -1;
      case (op)
         OP_PREPEND, OP_APPEND: begin
            if (held_items.size() >= DEPTH) begin
               r.status = STS_FULL;          // insert when full: no change
            end else if (op == OP_PREPEND) begin
               held_items.push_front(key);
            end else begin
               held_items.push_back(key);
            end
         end
         OP_DEQUEUE: begin
            if (held_items.size() == 0) begin
               r.status = STS_EMPTY;         // item stays 0
            end else begin
               r.item = held_items.pop_front();
            end
         end
         default: begin
            if (held_items.size() == 0) begin
               r.status = STS_EMPTY;
            end else begin
               // first match from the head; later entries close the gap
               foreach (held_items[i]) begin
                  if (pos < 0 && held_items[i] == key) pos = i;
               end
               if (pos < 0) r.status = STS_NOT_FOUND;
               else held_items.delete(pos);
            end
         end
      endcase
      r.len = LEN_W'(held_items.size());
      return r;
   endfunction

   task automatic note_failure(input string what, input deque_rsp_type want,
                               input deque_rsp_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected status %0d item %h len %0d, got status %0d item %h len %0d",
                  $realtime, what, want.status, want.item, want.len,
                  got.status, got.item, got.len);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side. The request is held until accepted; the predictor runs at
   // the accepting edge, so the next key choice sees the updated contents.
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] key,
                               input logic fixed, input deque_rsp_type want);
      deque_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_request(op, key);
      owed_rsp.push_back(fixed ? want : predicted);
      sent_in_pass++;
      // random gap in the requests so bubbles land on every sequencer state
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // small pool on a quarter of items so duplicates turn up for delete
   function automatic logic [ITEM_W-1:0] pick_item();
      if ($urandom_range(0, 3) == 0) return ITEM_W'($urandom_range(0, 7));
      return $urandom;
   endfunction

   // delete key: mostly one that is held, else anything
   function automatic logic [ITEM_W-1:0] pick_delete_key();
      if (held_items.size() != 0 && $urandom_range(0, 99) < 70)
         return held_items[$urandom_range(0, held_items.size() - 1)];
      return pick_item();
   endfunction

   task automatic send_random(input logic [OP_W-1:0] op);
      if (op == OP_DELETE) send_request(op, pick_delete_key(), 1'b0, '0);
      else send_request(op, pick_item(), 1'b0, '0);
   endtask

   // fill until full, then a few more inserts that must come back FULL
   task automatic fill_burst();
      while (held_items.size() < DEPTH) begin
         if ($urandom_range(0, 99) < 90)
            send_random($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND);
         else
            send_random($urandom_range(0, 1) ? OP_DELETE : OP_DEQUEUE);
      end
      repeat ($urandom_range(2, 4))
         send_random($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND);
   endtask

   // drain to empty, then one to three removes on the empty deque
   task automatic drain_burst();
      while (held_items.size() != 0)
         send_random($urandom_range(0, 1) ? OP_DELETE : OP_DEQUEUE);
      repeat ($urandom_range(1, 3))
         send_random($urandom_range(0, 1) ? OP_DELETE : OP_DEQUEUE);
   endtask

   task automatic mixed_burst();
      repeat (40) send_random(OP_W'($urandom_range(0, 3)));
   endtask

   // ---------------------------------------------------------------------
   // Response side: random ready, plus one long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // checker: each response transaction against the oldest owed one
   always @(posedge clock) begin
      deque_rsp_type got;
      deque_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32]};
         if (owed_rsp.size() == 0) begin
            note_failure("response with none outstanding", '0, got);
         end else begin
            want = owed_rsp.pop_front();
            if (got.status !== want.status || got.item !== want.item ||
                got.len !== want.len)
               note_failure("response mismatch", want, got);
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      // Directed table. Typed rows are plain reads of the spec; the rest go
      // through the predictor (duplicates, middle/tail/head deletes).
      directed_rows = '{
         '{OP_DEQUEUE, 32'h0000_0000, 1'b1, '{STS_EMPTY,     32'h0,         7'd0}},
         '{OP_DELETE,  32'h0000_0000, 1'b1, '{STS_EMPTY,     32'h0,         7'd0}},
         '{OP_APPEND,  32'h0000_0000, 1'b1, '{STS_OK,        32'h0,         7'd1}},
         '{OP_PREPEND, 32'hFFFF_FFFF, 1'b1, '{STS_OK,        32'h0,         7'd2}},
         '{OP_APPEND,  32'hA5A5_A5A5, 1'b1, '{STS_OK,        32'h0,         7'd3}},
         '{OP_PREPEND, 32'h5A5A_5A5A, 1'b1, '{STS_OK,        32'h0,         7'd4}},
         '{OP_DELETE,  32'h1234_5678, 1'b1, '{STS_NOT_FOUND, 32'h0,         7'd4}},
         '{OP_APPEND,  32'h0000_0000, 1'b0, '0},   // duplicate of a held item
         '{OP_DELETE,  32'h0000_0000, 1'b0, '0},   // first of two matches
         '{OP_DEQUEUE, 32'h0000_0000, 1'b1, '{STS_OK,        32'h5A5A_5A5A, 7'd3}},
         '{OP_DELETE,  32'h0000_0000, 1'b0, '0},   // match at the tail
         '{OP_DELETE,  32'hFFFF_FFFF, 1'b0, '0},   // match at the head
         '{OP_DEQUEUE, 32'hFFFF_FFFF, 1'b0, '0},   // item_in ignored
         '{OP_DEQUEUE, 32'h0000_0000, 1'b1, '{STS_EMPTY,     32'h0,         7'd0}},
         '{OP_PREPEND, 32'h8000_0001, 1'b0, '0},
         '{OP_APPEND,  32'h7FFF_FFFE, 1'b0, '0},
         '{OP_DELETE,  32'h7FFF_FFFE, 1'b0, '0},
         '{OP_DELETE,  32'h8000_0001, 1'b0, '0},
         '{OP_DELETE,  32'h8000_0001, 1'b1, '{STS_EMPTY,     32'h0,         7'd0}}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].item,
                      directed_rows[i].fixed, directed_rows[i].want);

      // Random passes: sender-light/receiver-heavy idling, then reversed, then
      // none. Each pass opens with a fill so the full case is hit every time.
      for (int pass = 0; pass < 3; pass++) begin
         send_idle_pct = (pass == 0) ? 13 : (pass == 1) ? 61 : 0;
         recv_idle_pct = (pass == 0) ? 61 : (pass == 1) ? 13 : 0;
         // last pass: receiver holds off while requests keep coming, so the
         // parked result fills and req_tready drops
         if (pass == 2) hold_pending = 1'b1;
         sent_in_pass = 0;
         fill_burst();
         while (sent_in_pass < ITEMS_PER_PASS) begin
            case ($urandom_range(0, 3))
               0:       fill_burst();
               1:       drain_burst();
               default: mixed_burst();
            endcase
         end
      end
      req_tvalid <= 1'b0;

      // wait out every owed response; the watchdog bounds this
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && owed_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> deque_with_delete_by_value_top.f
design/dqd_pkg.sv
design/deque_with_delete_by_value_top.sv
dv/tb.sv
